@@ src/tdrm_pkg.sv @@
// Shared types, codes and constants for the transmit descriptor ring.
// Used by the top level and the testbench; depends on nothing.
package tdrm_pkg;

    localparam int RING_DEPTH = 256;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

    // Operation kinds
    localparam logic [2:0] KIND_POST     = 3'd0;
    localparam logic [2:0] KIND_COMPLETE = 3'd1;
    localparam logic [2:0] KIND_RECLAIM  = 3'd2;
    localparam logic [2:0] KIND_INTR     = 3'd3;
    localparam logic [2:0] KIND_CONS     = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    // Marking
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] TOS_STREAM_A  = 8'h50;
    localparam logic [7:0] TOS_STREAM_B  = 8'h51;
    localparam logic [6:0] MARK_STREAM_A = 7'd10;
    localparam logic [6:0] MARK_STREAM_B = 7'd11;
    localparam logic [6:0] MARK_DEFAULT  = 7'd99;

    localparam logic [3:0] BUF_COUNT_ONE = 4'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  buf_count;
        logic [63:0] cookie;
        logic [63:0] buf_addr;
        logic [31:0] buf_len;
        logic [7:0]  ip_protocol;
        logic [7:0]  type_of_service;
        logic [31:0] min_completed;
        logic [31:0] new_consumer;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_cookie;
        logic [63:0] out_addr;
        logic [31:0] out_len;
        logic [6:0]  class_mark;
        logic        kick_needed;
    } out_item_t;

    // One ring descriptor as stored
    typedef struct packed {
        logic [63:0] cookie;
        logic [63:0] addr;
        logic [31:0] len;
        logic [6:0]  mark;
    } slot_t;

    localparam int SLOT_DATA_W = $bits(slot_t);

    function automatic logic [6:0] class_of(input logic [7:0] proto, input logic [7:0] tos);
        logic [6:0] mark;
        mark = MARK_DEFAULT;
        if (proto == PROTO_ICMP && tos == TOS_STREAM_A)
            mark = MARK_STREAM_A;
        else if (proto == PROTO_ICMP && tos == TOS_STREAM_B)
            mark = MARK_STREAM_B;
        return mark;
    endfunction

    // Slot of idx+1, given the slot of idx: wraps at the ring depth, and
    // returns to zero when the 32-bit index itself wraps.
    function automatic logic [SLOT_W-1:0] slot_advance(input logic [31:0] idx,
                                                       input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] nxt;
        if (idx == 32'hFFFF_FFFF || slot == SLOT_LAST)
            nxt = '0;
        else
            nxt = slot + SLOT_W'(1);
        return nxt;
    endfunction

endpackage

@@ src/tdrm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the descriptor ring storage.
module tdrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tx_descriptor_ring_with_marking_unit.sv @@
// Transmit descriptor ring with split producer, consumer and clear indices.
// Depends on tdrm_pkg and tdrm_ram.

// The block takes one operation per transfer on the input channel and gives
// exactly one result per operation, in order. It accepts a new operation in
// every cycle while the output side keeps up. out_valid rises once the
// result has moved from stage 1 into the output register. The index update
// and the ring access happen at the input transfer, the ring RAM's registered
// read forms stage 1, and the output register loads from stage 1 and holds
// the result until it is taken. Back-pressure on the output stalls the
// pipeline without losing data. The 32-bit indices are free-running; slots
// are tracked by separate wrapping pointers, so no division by the ring
// depth is needed. Ring slots have no reset: completing or reclaiming a slot
// that was never posted returns arbitrary contents. The kick register is
// written via cfg_we/cfg_wdata, only while idle: the user's duty, not enforced.
module tx_descriptor_ring_with_marking_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tdrm_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tdrm_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);

    import tdrm_pkg::*;

    // Configuration: backend wants a notification after each post
    logic notify_en_reg;

    // Ring indices and slot pointers
    logic [31:0]       producer_index_reg,  producer_index_next;
    logic [31:0]       consumer_index_reg,  consumer_index_next;
    logic [31:0]       clear_index_reg,     clear_index_next;
    logic [31:0]       interrupt_index_reg, interrupt_index_next;
    logic [SLOT_W-1:0] prod_slot_reg,       prod_slot_next;
    logic [SLOT_W-1:0] clear_slot_reg,      clear_slot_next;

    // Stage 1: control alongside the RAM read register
    logic       s1_valid_reg;
    logic       s1_take_reg,   s1_take_next;
    logic [1:0] s1_status_reg, s1_status_next;
    logic [6:0] s1_mark_reg,   s1_mark_next;
    logic       s1_kick_reg,   s1_kick_next;

    // Output register
    logic      out_valid_reg;
    out_item_t out_reg, out_next;

    logic      accept;
    logic      s1_go;
    logic      ram_we, ram_re;
    logic      intr_below;
    logic [31:0] done_count;
    slot_t     wr_slot, rd_slot;

    // Handshake: stage 1 drains into the output register whenever that one
    // is empty or being taken; the input side follows stage 1.
    assign s1_go    = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    assign done_count = consumer_index_reg - clear_index_reg;

    // Operation decode and next-state logic, applied at the input transfer
    always_comb
    begin
        producer_index_next  = producer_index_reg;
        consumer_index_next  = consumer_index_reg;
        clear_index_next     = clear_index_reg;
        interrupt_index_next = interrupt_index_reg;
        prod_slot_next       = prod_slot_reg;
        clear_slot_next      = clear_slot_reg;
        ram_we               = 1'b0;
        ram_re               = 1'b0;
        intr_below           = 1'b0;
        s1_take_next         = 1'b0;
        s1_status_next       = STATUS_NONE;
        s1_mark_next         = '0;
        s1_kick_next         = 1'b0;

        case (in_data.kind)
            KIND_POST:
            begin
                if (in_data.buf_count != BUF_COUNT_ONE)
                begin
                    s1_status_next = STATUS_ERR;
                end
                else
                begin
                    ram_we              = 1'b1;
                    producer_index_next = producer_index_reg + 32'd1;
                    prod_slot_next      = slot_advance(producer_index_reg, prod_slot_reg);
                    s1_status_next      = STATUS_DONE;
                    s1_mark_next        = class_of(in_data.ip_protocol,
                                                   in_data.type_of_service);
                    s1_kick_next        = notify_en_reg;
                end
            end
            KIND_COMPLETE:
            begin
                if (clear_index_reg != consumer_index_reg)
                begin
                    ram_re           = 1'b1;
                    s1_take_next     = 1'b1;
                    s1_status_next   = STATUS_DONE;
                    clear_index_next = clear_index_reg + 32'd1;
                    clear_slot_next  = slot_advance(clear_index_reg, clear_slot_reg);
                end
            end
            KIND_RECLAIM:
            begin
                if (clear_index_reg != producer_index_reg)
                begin
                    ram_re           = 1'b1;
                    s1_take_next     = 1'b1;
                    s1_status_next   = STATUS_DONE;
                    clear_index_next = clear_index_reg + 32'd1;
                    clear_slot_next  = slot_advance(clear_index_reg, clear_slot_reg);
                    // consumer had met clear: drag it along
                    if (clear_index_reg == consumer_index_reg)
                        consumer_index_next = clear_index_reg + 32'd1;
                end
            end
            KIND_INTR:
            begin
                if (in_data.min_completed != 32'd0)
                begin
                    if (done_count >= in_data.min_completed)
                    begin
                        s1_status_next = STATUS_DONE;
                    end
                    else
                    begin
                        intr_below           = 1'b1;
                        interrupt_index_next = clear_index_reg + in_data.min_completed
                                               - 32'd1;
                    end
                end
            end
            KIND_CONS:
            begin
                consumer_index_next = in_data.new_consumer;
                s1_status_next      = STATUS_DONE;
            end
            default:
            begin
                s1_status_next = STATUS_ERR;
            end
        endcase
    end

    assign wr_slot.cookie = in_data.cookie;
    assign wr_slot.addr   = in_data.buf_addr;
    assign wr_slot.len    = in_data.buf_len;
    assign wr_slot.mark   = s1_mark_next;

    // Ring storage; the read register holds while stage 1 is stalled
    tdrm_ram #(
        .WIDTH (SLOT_DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept && ram_we),
        .waddr (prod_slot_reg),
        .wdata (wr_slot),
        .re    (accept && ram_re),
        .raddr (clear_slot_reg),
        .rdata (rd_slot)
    );

    // Build the result: descriptor fields only for a returned entry
    always_comb
    begin
        out_next.status      = s1_status_reg;
        out_next.out_cookie  = s1_take_reg ? rd_slot.cookie : 64'd0;
        out_next.out_addr    = s1_take_reg ? rd_slot.addr   : 64'd0;
        out_next.out_len     = s1_take_reg ? rd_slot.len    : 32'd0;
        out_next.class_mark  = s1_mark_reg;
        out_next.kick_needed = s1_kick_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notify_en_reg       <= 1'b0;
            producer_index_reg  <= '0;
            consumer_index_reg  <= '0;
            clear_index_reg     <= '0;
            interrupt_index_reg <= '0;
            prod_slot_reg       <= '0;
            clear_slot_reg      <= '0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                notify_en_reg <= cfg_wdata;
            if (accept)
            begin
                producer_index_reg  <= producer_index_next;
                consumer_index_reg  <= consumer_index_next;
                clear_index_reg     <= clear_index_next;
                interrupt_index_reg <= interrupt_index_next;
                prod_slot_reg       <= prod_slot_next;
                clear_slot_reg      <= clear_slot_next;
            end
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_go)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers: advance with their stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_take_reg   <= s1_take_next;
            s1_status_reg <= s1_status_next;
            s1_mark_reg   <= s1_mark_next;
            s1_kick_reg   <= s1_kick_next;
        end
        if (s1_go && s1_valid_reg)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    // A stalled input is caused only by a full pipeline under back-pressure
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without output back-pressure");

    // A rejected post leaves the producer side untouched
    a_bad_post: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.kind == KIND_POST && in_data.buf_count != BUF_COUNT_ONE)
        |=> ($stable(producer_index_reg) && $stable(prod_slot_reg)))
        else $error("rejected post moved the producer");

    // A check below threshold records clear plus threshold minus one
    a_intr_index: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && intr_below)
        |=> interrupt_index_reg == $past(clear_index_reg + in_data.min_completed - 32'd1))
        else $error("interrupt index not recorded");
`endif

endmodule

@@ tb/tdrm_ring_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the transmit descriptor ring: tracks the ring state from
// observed transfers, predicts one result per operation and compares in order.
// Depends on tdrm_pkg; instantiated beside the DUT by the testbench top.
module tdrm_ring_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  tdrm_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  tdrm_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output int                  failures,
    output int                  outstanding,
    output int                  checked
);
    import tdrm_pkg::*;

    logic        kick_on;
    logic [31:0] prod_idx;
    logic [31:0] cons_idx;
    logic [31:0] clr_idx;
    logic [31:0] irq_idx;
    slot_t       ring_slots [RING_DEPTH];
    out_item_t   pending_results [$];
    out_item_t   want;

    // Apply one operation to the tracked ring and return the result it owes.
    function automatic out_item_t ring_outcome(input in_item_t op);
        out_item_t res;
        slot_t     ent;
        logic      met;
        res = '0;
        case (op.kind)
            KIND_POST:
            begin
                if (op.buf_count != BUF_COUNT_ONE)
                    res.status = STATUS_ERR;
                else
                begin
                    ent.cookie = op.cookie;
                    ent.addr   = op.buf_addr;
                    ent.len    = op.buf_len;
                    if (op.ip_protocol != PROTO_ICMP)
                        ent.mark = MARK_DEFAULT;
                    else if (op.type_of_service == TOS_STREAM_A)
                        ent.mark = MARK_STREAM_A;
                    else if (op.type_of_service == TOS_STREAM_B)
                        ent.mark = MARK_STREAM_B;
                    else
                        ent.mark = MARK_DEFAULT;
                    ring_slots[prod_idx % RING_DEPTH] = ent;
                    prod_idx = prod_idx + 32'd1;
                    res.status      = STATUS_DONE;
                    res.class_mark  = ent.mark;
                    res.kick_needed = kick_on;
                end
            end
            KIND_COMPLETE, KIND_RECLAIM:
            begin
                met = (clr_idx == cons_idx);
                if ((op.kind == KIND_COMPLETE) ? !met : (clr_idx != prod_idx))
                begin
                    ent = ring_slots[clr_idx % RING_DEPTH];
                    res.status     = STATUS_DONE;
                    res.out_cookie = ent.cookie;
                    res.out_addr   = ent.addr;
                    res.out_len    = ent.len;
                    clr_idx = clr_idx + 32'd1;
                    // a reclaim drags the consumer index along when it had met clear
                    if (op.kind == KIND_RECLAIM && met)
                        cons_idx = clr_idx;
                end
            end
            KIND_INTR:
            begin
                if (op.min_completed != 32'd0)
                begin
                    if (cons_idx - clr_idx >= op.min_completed)
                        res.status = STATUS_DONE;
                    else
                        irq_idx = clr_idx + op.min_completed - 32'd1;
                end
            end
            KIND_CONS:
            begin
                cons_idx   = op.new_consumer;
                res.status = STATUS_DONE;
            end
            default:
                res.status = STATUS_ERR;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_on     = 1'b0;
            prod_idx    = '0;
            cons_idx    = '0;
            clr_idx     = '0;
            irq_idx     = '0;
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                kick_on = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: status %0d cookie %h",
                                 out_data.status, out_data.out_cookie);
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked++;
                    if (out_data.status !== want.status ||
                        out_data.out_cookie !== want.out_cookie ||
                        out_data.out_addr !== want.out_addr ||
                        out_data.out_len !== want.out_len ||
                        out_data.class_mark !== want.class_mark ||
                        out_data.kick_needed !== want.kick_needed)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("result %0d mismatch (expected/actual): status %0d/%0d",
                                     checked, want.status, out_data.status,
                                     " mark %0d/%0d kick %0d/%0d",
                                     want.class_mark, out_data.class_mark,
                                     want.kick_needed, out_data.kick_needed);
                            $display("  cookie %h/%h addr %h/%h len %h/%h",
                                     want.out_cookie, out_data.out_cookie,
                                     want.out_addr, out_data.out_addr,
                                     want.out_len, out_data.out_len);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(ring_outcome(in_data));
            outstanding = pending_results.size();
        end
    end

endmodule

@@ tb/tb_tx_descriptor_ring_with_marking_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the transmit descriptor ring: drives operations and the
// kick register, applies back-pressure and gives the verdict.
// Depends on tdrm_pkg, the DUT and tdrm_ring_checker.
module tb_tx_descriptor_ring_with_marking_unit;
    import tdrm_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          HOLD_CYCLES = 120;
    localparam longint      TIMEOUT_NS  = 5_000_000;
    // kinds with no meaning; the block must reject them
    localparam logic [2:0]  KIND_UNKNOWN_LO = 3'd5;
    localparam logic [2:0]  KIND_UNKNOWN_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    logic      cfg_wdata;

    int failures;
    int outstanding;
    int checked;

    // Idle controls shared between the stimulus and the receiver
    int gap_pct   = 0;
    int stall_pct = 0;
    bit squeeze   = 1'b0;
    int holds_done = 0;

    // Shadow of the ring indices, used to pick thresholds and consumer values and
    // so that the stimulus never completes or reclaims a slot not yet posted.
    logic [31:0] sh_prod = '0;
    logic [31:0] sh_cons = '0;
    logic [31:0] sh_clr  = '0;
    bit          slot_posted [RING_DEPTH];
    int          kind_count [8];

    always #(CLK_PERIOD / 2) clk = ~clk;

    tx_descriptor_ring_with_marking_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tdrm_ring_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .failures    (failures),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Fill every field with random bits; callers then set what matters.
    function automatic in_item_t noise_item();
        in_item_t op;
        op.kind            = KIND_POST;
        op.buf_count       = 4'($urandom_range(0, 15));
        op.cookie          = {$urandom, $urandom};
        op.buf_addr        = {$urandom, $urandom};
        op.buf_len         = $urandom;
        op.ip_protocol     = 8'($urandom);
        op.type_of_service = 8'($urandom);
        op.min_completed   = $urandom;
        op.new_consumer    = $urandom;
        return op;
    endfunction

    // Mostly well-formed ring traffic: posts, completes and reclaims that
    // hit real descriptors, sensible consumer updates and thresholds near
    // the current backlog. The rest is malformed posts, unknown kinds and
    // wild consumer values.
    function automatic in_item_t random_op(input int post_pct);
        in_item_t    op;
        int          roll;
        logic [31:0] span;
        op   = noise_item();
        roll = $urandom_range(0, 99);
        if (roll < post_pct)
        begin
            op.kind      = KIND_POST;
            op.buf_count = BUF_COUNT_ONE;
            case ($urandom_range(0, 4))
                0:
                begin
                    op.ip_protocol     = PROTO_ICMP;
                    op.type_of_service = TOS_STREAM_A;
                end
                1:
                begin
                    op.ip_protocol     = PROTO_ICMP;
                    op.type_of_service = TOS_STREAM_B;
                end
                2:
                    op.ip_protocol = PROTO_ICMP;
                3:
                    op.type_of_service = $urandom_range(0, 1) ? TOS_STREAM_A : TOS_STREAM_B;
                default:
                    ;
            endcase
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                op.kind = KIND_COMPLETE;
            else if (roll < 55)
                op.kind = KIND_RECLAIM;
            else if (roll < 70)
            begin
                op.kind = KIND_INTR;
                span    = sh_cons - sh_clr;
                case ($urandom_range(0, 3))
                    0:       op.min_completed = '0;
                    1:       ;
                    default:
                    begin
                        if (span <= 32'd1000)
                            op.min_completed = span + 32'($urandom_range(0, 2)) - 32'd1;
                    end
                endcase
            end
            else if (roll < 88)
            begin
                // publish a consumer index somewhere between clear and producer
                op.kind = KIND_CONS;
                span    = sh_prod - sh_clr;
                if (span > 32'd512)
                    span = 32'd4;
                op.new_consumer = sh_clr + 32'($urandom_range(0, span));
            end
            else if (roll < 93)
                op.buf_count = 4'($urandom_range(2, 16));
            else if (roll < 97)
                op.kind = 3'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI));
            else
                op.kind = KIND_CONS;
        end
        // swap a read of a never-posted slot for a post
        if (((op.kind == KIND_COMPLETE && sh_clr != sh_cons) ||
             (op.kind == KIND_RECLAIM && sh_clr != sh_prod)) &&
            !slot_posted[sh_clr % RING_DEPTH])
        begin
            op.kind      = KIND_POST;
            op.buf_count = BUF_COUNT_ONE;
        end
        return op;
    endfunction

    // Offer one operation and hold it until the transfer. Called and
    // returning at a falling edge; valid stays high for back-to-back items.
    task automatic send_op(input in_item_t op);
        logic met;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_data  <= op;
        in_valid <= 1'b1;
        kind_count[op.kind]++;
        // advance the shadow indices the same way the ring will
        case (op.kind)
            KIND_POST:
            begin
                if (op.buf_count == BUF_COUNT_ONE)
                begin
                    slot_posted[sh_prod % RING_DEPTH] = 1'b1;
                    sh_prod = sh_prod + 32'd1;
                end
            end
            KIND_COMPLETE:
            begin
                if (sh_clr != sh_cons)
                    sh_clr = sh_clr + 32'd1;
            end
            KIND_RECLAIM:
            begin
                if (sh_clr != sh_prod)
                begin
                    met    = (sh_clr == sh_cons);
                    sh_clr = sh_clr + 32'd1;
                    if (met)
                        sh_cons = sh_clr;
                end
            end
            KIND_CONS:
                sh_cons = op.new_consumer;
            default:
                ;
        endcase
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic post(input logic [3:0] count, input logic [63:0] cookie,
                        input logic [63:0] addr, input logic [31:0] len,
                        input logic [7:0] proto, input logic [7:0] tos);
        in_item_t op;
        op                 = noise_item();
        op.kind            = KIND_POST;
        op.buf_count       = count;
        op.cookie          = cookie;
        op.buf_addr        = addr;
        op.buf_len         = len;
        op.ip_protocol     = proto;
        op.type_of_service = tos;
        send_op(op);
    endtask

    task automatic send_cmd(input logic [2:0] kind, input logic [31:0] thr,
                            input logic [31:0] cons);
        in_item_t op;
        op               = noise_item();
        op.kind          = kind;
        op.min_completed = thr;
        op.new_consumer  = cons;
        send_op(op);
    endtask

    // Drop valid, drain every pending result, let the pipeline settle,
    // then write the kick register for one cycle.
    task automatic write_kick(input logic value);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int count, input int post_pct);
        repeat (count)
            send_op(random_op(post_pct));
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    // that lets the block fill and push back on its input.
    initial
    begin
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (squeeze)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                squeeze = 1'b0;
                holds_done++;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int k;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_kick(1'b1);

        // Directed: empty ring, threshold edge cases and bad counts first
        send_cmd(KIND_COMPLETE, '0, '0);
        send_cmd(KIND_RECLAIM, '0, '0);
        send_cmd(KIND_INTR, 32'd0, '0);
        send_cmd(KIND_INTR, 32'd1, '0);
        post(4'd0, '1, '1, '1, PROTO_ICMP, TOS_STREAM_A);
        post(4'd15, '1, '1, '1, PROTO_ICMP, TOS_STREAM_A);
        post(4'd2, '0, '0, '0, PROTO_ICMP, TOS_STREAM_B);
        // posts covering every marking class, field extremes in the descriptor
        post(BUF_COUNT_ONE, '1, '1, '1, PROTO_ICMP, TOS_STREAM_A);
        post(BUF_COUNT_ONE, '0, '0, '0, PROTO_ICMP, TOS_STREAM_B);
        post(BUF_COUNT_ONE, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
             32'h8000_0001, PROTO_ICMP, 8'h52);
        post(BUF_COUNT_ONE, 64'h8000_0000_0000_0000, 64'h1, 32'h1, 8'h00, TOS_STREAM_A);
        post(BUF_COUNT_ONE, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555,
             32'h7fff_ffff, 8'hff, 8'hff);
        for (k = KIND_UNKNOWN_LO; k <= KIND_UNKNOWN_HI; k++)
            send_cmd(3'(k), $urandom, $urandom);
        // backend consumes two; threshold met, then an unreachable one
        send_cmd(KIND_CONS, '0, 32'd2);
        send_cmd(KIND_INTR, 32'd2, '0);
        send_cmd(KIND_INTR, 32'hffff_ffff, '0);
        send_cmd(KIND_COMPLETE, '0, '0);
        send_cmd(KIND_COMPLETE, '0, '0);
        send_cmd(KIND_COMPLETE, '0, '0);
        // reclaim with consumer sitting on clear moves the consumer too
        send_cmd(KIND_RECLAIM, '0, '0);
        send_cmd(KIND_COMPLETE, '0, '0);
        // consumer jumps far ahead; backlog wraps just below the threshold
        send_cmd(KIND_CONS, '0, 32'hffff_ffff);
        send_cmd(KIND_INTR, 32'hffff_ffff, '0);
        send_cmd(KIND_COMPLETE, '0, '0);
        send_cmd(KIND_CONS, '0, 32'd4);

        // Random phase with gaps and stalls on both sides
        write_kick(1'b0);
        gap_pct   = 20;
        stall_pct = 20;
        run_random(250, 35);

        // Back-to-back transfers, no idling anywhere
        write_kick(1'b1);
        gap_pct   = 0;
        stall_pct = 0;
        run_random(250, 35);

        // Post-heavy burst under a long output hold-off; the ring wraps
        write_kick(1'b0);
        stall_pct = 25;
        squeeze   = 1'b1;
        run_random(260, 70);

        // Closing stretch at full rate
        write_kick(1'b1);
        stall_pct = 0;
        run_random(265, 35);

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Covered %0d posts, %0d completes, %0d reclaims, %0d interrupt checks,",
                 kind_count[KIND_POST], kind_count[KIND_COMPLETE],
                 kind_count[KIND_RECLAIM], kind_count[KIND_INTR],
                 " %0d consumer updates, %0d unknown kinds",
                 kind_count[KIND_CONS], kind_count[5] + kind_count[6] + kind_count[7]);
        $display("%0d results checked with kick on and off, %0d long output hold-off(s)",
                 checked, holds_done);
        if (failures == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: fail if the run never drains
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
src/tdrm_pkg.sv
src/tdrm_ram.sv
src/tx_descriptor_ring_with_marking_unit.sv
tb/tdrm_ring_checker.sv
tb/tb_tx_descriptor_ring_with_marking_unit.sv
